// ===== src/gai_pkg.sv =====
// gai_pkg: shared types and constants of the gyro angle integrator.
// No dependencies; every other file of the block imports it.

package gai_pkg;

    // Field widths fixed by the item format
    localparam int RATE_W     = 16;
    localparam int MAG_OUT_W  = 8;
    localparam int SPS_W      = 10;
    localparam int DB_W       = 25;
    localparam int WHOLE_W    = 9;    // whole degrees 0..360
    localparam int PROD_W     = 27;   // 17-bit magnitude times 1000

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 25;

    // Axes
    localparam int NUM_AXES   = 3;
    localparam int AXIS_W     = 2;

    // Fixed-point scaling
    localparam int RAW_FRAC   = 16;   // rates are formed in Q16 first
    localparam int MAX_FRAC   = 24;   // largest supported fraction width

    // Constants of the conversion
    localparam int DEG_FULL   = 360;
    localparam int DEG_HALF   = 180;
    localparam int RATE_SCALE = 1000;

    // Register reset values (deadband is 0.7 deg/s in Q16)
    localparam logic [SPS_W-1:0] SPS_RESET = 10'd100;
    localparam logic [DB_W-1:0]  DB_RESET  = 25'd45875;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SPS      = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND = 1'b1;

    // Opcodes
    localparam logic OP_INTEGRATE = 1'b0;
    localparam logic OP_RECENTER  = 1'b1;

    // Last axis index
    localparam logic [AXIS_W-1:0] AXIS_LAST = 2'd2;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_UPD,
        ST_EMIT
    } state_t;

    // Divider handshake
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

// ===== src/gai_if.sv =====
// gai_if: request channels of the gyro angle integrator (input sample, result).
// Depends on gai_pkg.

interface gai_in_if import gai_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic                     opcode;
    logic signed [RATE_W-1:0] rate_x;
    logic signed [RATE_W-1:0] rate_y;
    logic signed [RATE_W-1:0] rate_z;

    modport source (output valid, output opcode, output rate_x, output rate_y,
                    output rate_z, input ready);
    modport sink   (input valid, input opcode, input rate_x, input rate_y,
                    input rate_z, output ready);
endinterface

interface gai_out_if import gai_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 sign_x;
    logic [MAG_OUT_W-1:0] mag_x;
    logic                 sign_y;
    logic [MAG_OUT_W-1:0] mag_y;
    logic                 sign_z;
    logic [MAG_OUT_W-1:0] mag_z;

    modport source (output valid, output sign_x, output mag_x, output sign_y,
                    output mag_y, output sign_z, output mag_z, input ready);
    modport sink   (input valid, input sign_x, input mag_x, input sign_y,
                    input mag_y, input sign_z, input mag_z, output ready);
endinterface

// ===== src/gyro_angle_integrator_top.sv =====
// gyro_angle_integrator_top: sequencer, angle store and result register.
// Depends on gai_pkg, gai_if, gai_serial_div and gai_fold.

// Three-axis gyro angle integrator. Each request carries three raw 16-bit
// readings and an opcode; every request yields one result with a sign and a
// whole-degree magnitude (0..180) per axis. One bit-serial divider is shared
// by the axes in turn and produces one quotient bit per cycle; an axis whose
// rate lies within the deadband skips its division. One request is in work at
// a time; the next is taken while the previous result still waits in the
// output register.
// Registers: index 0 samples_per_second (0 acts as 1), index 1 deadband.

module gyro_angle_integrator_top import gai_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    gai_in_if.sink                in_ch,
    gai_out_if.source             out_ch
);

    localparam int ANG_W = FRAC_BITS + WHOLE_W;
    localparam int CMP_W = (ANG_W > DB_W) ? ANG_W : DB_W;
    localparam int WIDE_W = PROD_W + MAX_FRAC - RAW_FRAC;
    localparam logic [ANG_W-1:0] FULL_TURN = ANG_W'(DEG_FULL) << FRAC_BITS;

    // Registers
    state_t                   state_reg, state_next;
    logic [AXIS_W-1:0]        axis_reg, axis_next;
    logic [ANG_W-1:0]         angle_reg [NUM_AXES];
    logic [ANG_W-1:0]         angle_next [NUM_AXES];
    logic [RATE_W-1:0]        rate_reg [NUM_AXES];
    logic [SPS_W-1:0]         sps_reg;
    logic [DB_W-1:0]          deadband_reg;
    logic                     out_valid_reg, out_valid_next;
    logic                     sign_reg [NUM_AXES];
    logic [MAG_OUT_W-1:0]     mag_reg [NUM_AXES];

    // Combinational signals
    logic                     in_fire;
    logic                     out_load;
    logic [RATE_W-1:0]        rate_cur;
    logic                     rate_neg;
    logic [RATE_W:0]          rate_abs;
    logic [PROD_W-1:0]        prod;
    logic [WIDE_W-1:0]        prod_wide;
    logic [ANG_W-1:0]         mag_cur;
    logic                     above_db;
    logic [SPS_W-1:0]         divisor;
    logic                     div_start;
    div_status_t              div_status;
    logic [ANG_W-1:0]         quotient;
    logic [ANG_W-1:0]         inc;
    logic [ANG_W-1:0]         angle_cur;
    logic [ANG_W:0]           sum;
    logic [ANG_W:0]           diff;
    logic [ANG_W-1:0]         angle_upd;
    logic                     fold_sign [NUM_AXES];
    logic [MAG_OUT_W-1:0]     fold_mag [NUM_AXES];

    assign in_fire = in_ch.valid && in_ch.ready;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sps_reg      <= SPS_RESET;
            deadband_reg <= DB_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SPS:      sps_reg      <= cfg_data[SPS_W-1:0];
                CFG_DEADBAND: deadband_reg <= cfg_data[DB_W-1:0];
                default:      ;
            endcase
        end
    end

    // Rate magnitude of the current axis, scaled to Q(FRAC_BITS)
    assign rate_cur  = rate_reg[axis_reg];
    assign rate_neg  = rate_cur[RATE_W-1];
    assign rate_abs  = rate_neg ? (~{1'b1, rate_cur} + (RATE_W+1)'(1)) : {1'b0, rate_cur};
    assign prod      = PROD_W'(rate_abs) * PROD_W'(RATE_SCALE);
    assign prod_wide = {prod, (MAX_FRAC - RAW_FRAC)'(0)};
    assign mag_cur   = ANG_W'(prod_wide >> (MAX_FRAC - FRAC_BITS));
    assign above_db  = CMP_W'(mag_cur) > CMP_W'(deadband_reg);
    assign divisor   = (sps_reg == '0) ? SPS_W'(1) : sps_reg;

    gai_serial_div #(
        .DIVIDEND_W (ANG_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (mag_cur),
        .divisor  (divisor),
        .status   (div_status),
        .quotient (quotient)
    );

    // Increment reduced below a full turn, then added or subtracted modulo 360
    assign inc       = (quotient >= FULL_TURN) ? (quotient - FULL_TURN) : quotient;
    assign angle_cur = angle_reg[axis_reg];
    assign sum       = {1'b0, angle_cur} + {1'b0, inc};
    assign diff      = {1'b0, angle_cur} - {1'b0, inc};

    always_comb
    begin
        if (rate_neg)
            angle_upd = diff[ANG_W] ? ANG_W'(diff + {1'b0, FULL_TURN}) : diff[ANG_W-1:0];
        else
            angle_upd = (sum >= {1'b0, FULL_TURN}) ? ANG_W'(sum - {1'b0, FULL_TURN})
                                                   : sum[ANG_W-1:0];
    end

    // Result folding for all axes
    for (genvar a = 0; a < NUM_AXES; a++)
    begin : g_fold
        gai_fold #(
            .FRAC_BITS (FRAC_BITS)
        ) u_fold (
            .angle (angle_reg[a]),
            .sign  (fold_sign[a]),
            .mag   (fold_mag[a])
        );
    end

    // State register and angle store
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            axis_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_AXES; i++)
                angle_reg[i] <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            axis_reg      <= axis_next;
            out_valid_reg <= out_valid_next;
            for (int i = 0; i < NUM_AXES; i++)
                angle_reg[i] <= angle_next[i];
        end
    end

    // Sample and result payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            rate_reg[0] <= in_ch.rate_x;
            rate_reg[1] <= in_ch.rate_y;
            rate_reg[2] <= in_ch.rate_z;
        end
        if (out_load)
        begin
            for (int i = 0; i < NUM_AXES; i++)
            begin
                sign_reg[i] <= fold_sign[i];
                mag_reg[i]  <= fold_mag[i];
            end
        end
    end

    // Next state and outputs
    always_comb
    begin
        state_next  = state_reg;
        axis_next   = axis_reg;
        angle_next  = angle_reg;
        div_start   = 1'b0;
        out_load    = 1'b0;
        in_ch.ready = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ch.ready = 1'b1;
                if (in_ch.valid)
                begin
                    axis_next = '0;
                    if (in_ch.opcode == OP_RECENTER)
                    begin
                        for (int i = 0; i < NUM_AXES; i++)
                            angle_next[i] = '0;
                        state_next = ST_EMIT;
                    end
                    else
                        state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (above_db)
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
                else if (axis_reg == AXIS_LAST)
                    state_next = ST_EMIT;
                else
                    axis_next = axis_reg + AXIS_W'(1);
            end
            ST_DIV:
            begin
                if (div_status.done)
                    state_next = ST_UPD;
            end
            ST_UPD:
            begin
                angle_next[axis_reg] = angle_upd;
                if (axis_reg == AXIS_LAST)
                    state_next = ST_EMIT;
                else
                begin
                    axis_next  = axis_reg + AXIS_W'(1);
                    state_next = ST_CHECK;
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase

        // Result register holds until taken
        if (out_load)
            out_valid_next = 1'b1;
        else if (out_ch.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign out_ch.valid  = out_valid_reg;
    assign out_ch.sign_x = sign_reg[0];
    assign out_ch.mag_x  = mag_reg[0];
    assign out_ch.sign_y = sign_reg[1];
    assign out_ch.mag_y  = mag_reg[1];
    assign out_ch.sign_z = sign_reg[2];
    assign out_ch.mag_z  = mag_reg[2];

    // Angles stay below a full turn
    assert property (@(posedge clk) disable iff (!rst_n)
        (angle_reg[0] < FULL_TURN) && (angle_reg[1] < FULL_TURN) &&
        (angle_reg[2] < FULL_TURN))
        else $error("angle out of range");

    // Divider finishes only while the sequencer waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        div_status.done |-> (state_reg == ST_DIV))
        else $error("divider done outside wait state");

    // Divider runs only while the sequencer waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        div_status.busy |-> (state_reg == ST_DIV))
        else $error("divider busy outside wait state");

    // A recenter request clears every angle
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (in_ch.opcode == OP_RECENTER)) |=>
        ((angle_reg[0] == '0) && (angle_reg[1] == '0) && (angle_reg[2] == '0)))
        else $error("recenter did not clear angles");

    // A new result appears only from the emit state
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_EMIT))
        else $error("result without emit");

endmodule

// ===== src/gai_serial_div.sv =====
// gai_serial_div: restoring divider, one quotient bit per cycle.
// Depends on gai_pkg.

module gai_serial_div import gai_pkg::*; #(
    parameter int DIVIDEND_W = 25
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [SPS_W-1:0]      divisor,
    output div_status_t           status,
    output logic [DIVIDEND_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  busy_reg;
    logic                  done_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [SPS_W-1:0]      rem_reg;
    logic [SPS_W-1:0]      dvs_reg;
    logic [DIVIDEND_W-1:0] shift_reg;

    logic [SPS_W:0]        trial;
    logic                  qbit;

    // Trial subtraction of the divisor from the shifted remainder
    assign trial = {rem_reg, shift_reg[DIVIDEND_W-1]};
    assign qbit  = (trial >= {1'b0, dvs_reg});

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CNT_W'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIVIDEND_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                    busy_reg <= 1'b0;
            end
        end
    end

    // Datapath: dividend bits leave at the top, quotient bits enter at the bottom
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            shift_reg <= dividend;
            rem_reg   <= '0;
            dvs_reg   <= divisor;
        end
        else if (busy_reg)
        begin
            shift_reg <= {shift_reg[DIVIDEND_W-2:0], qbit};
            rem_reg   <= qbit ? SPS_W'(trial - {1'b0, dvs_reg}) : trial[SPS_W-1:0];
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = shift_reg;

endmodule

// ===== src/gai_fold.sv =====
// gai_fold: rounds an angle to whole degrees (ties to even) and folds it
// into a sign and a 0..180 magnitude. Depends on gai_pkg.

module gai_fold import gai_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic [FRAC_BITS+WHOLE_W-1:0] angle,
    output logic                         sign,
    output logic [MAG_OUT_W-1:0]         mag
);

    localparam logic [FRAC_BITS-1:0] HALF = FRAC_BITS'(1) << (FRAC_BITS - 1);

    logic [WHOLE_W-1:0]   whole;
    logic [FRAC_BITS-1:0] frac;
    logic                 round_up;
    logic [WHOLE_W-1:0]   whole_rnd;
    logic [WHOLE_W-1:0]   whole_wrap;

    assign whole    = angle[FRAC_BITS +: WHOLE_W];
    assign frac     = angle[FRAC_BITS-1:0];
    assign round_up = (frac > HALF) || ((frac == HALF) && whole[0]);

    // Rounding up to a full turn wraps to zero
    assign whole_rnd  = whole + WHOLE_W'(round_up);
    assign whole_wrap = (whole_rnd >= WHOLE_W'(DEG_FULL)) ? '0 : whole_rnd;

    // Upper half of the circle reads as negative
    always_comb
    begin
        if (whole_wrap > WHOLE_W'(DEG_HALF))
        begin
            sign = 1'b1;
            mag  = MAG_OUT_W'(WHOLE_W'(DEG_FULL) - whole_wrap);
        end
        else
        begin
            sign = 1'b0;
            mag  = whole_wrap[MAG_OUT_W-1:0];
        end
    end

endmodule
